>>> hdl/hnlru_pkg.sv
// shared types and command codes for the hybrid sram/nvm lru victim block
`timescale 1ns / 1ps

package hnlru_pkg;

    localparam int STAMP_W = 32;
    localparam int LABEL_W = 5;

    typedef enum logic [1:0] {
        CMD_TOUCH  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_VICTIM = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] way_index;
    } item_t;

    typedef struct packed {
        logic [3:0]         victim_index;
        logic [LABEL_W-1:0] victim_label;
        logic               oldest_was_nvm;
        logic               swapped;
    } result_t;

    typedef struct packed {
        logic lt_oldest;
        logic lt_sram;
    } cmp_t;

endpackage

>>> hdl/hnlru_way_store.sv
// per-entry age stamps, nvm flags and way labels with one scan read port
`timescale 1ns / 1ps

module hnlru_way_store #(
    parameter int NUM_WAYS  = 16,
    parameter int SRAM_WAYS = 3,
    parameter int IDX_W     = $clog2(NUM_WAYS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [IDX_W-1:0]                  rd_idx,
    output logic [hnlru_pkg::STAMP_W-1:0]     rd_age,
    output logic                              rd_nvm,
    output logic [hnlru_pkg::LABEL_W-1:0]     rd_label,
    input  logic                              age_we,
    input  logic [IDX_W-1:0]                  age_idx,
    input  logic [hnlru_pkg::STAMP_W-1:0]     age_data,
    input  logic                              lbl_we,
    input  logic [IDX_W-1:0]                  lbl_idx,
    input  logic                              lbl_nvm,
    input  logic [hnlru_pkg::LABEL_W-1:0]     lbl_data
);

    logic [hnlru_pkg::STAMP_W-1:0] age_reg   [NUM_WAYS];
    logic                          nvm_reg   [NUM_WAYS];
    logic [hnlru_pkg::LABEL_W-1:0] label_reg [NUM_WAYS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                age_reg[i]   <= '0;
                nvm_reg[i]   <= (i > SRAM_WAYS);
                label_reg[i] <= hnlru_pkg::LABEL_W'(i + 1);
            end
        end
        else
        begin
            if (age_we)
                age_reg[age_idx] <= age_data;
            if (lbl_we)
            begin
                nvm_reg[lbl_idx]   <= lbl_nvm;
                label_reg[lbl_idx] <= lbl_data;
            end
        end
    end

    assign rd_age   = age_reg[rd_idx];
    assign rd_nvm   = nvm_reg[rd_idx];
    assign rd_label = label_reg[rd_idx];

endmodule

>>> hdl/hnlru_cmp_unit.sv
// shared stamp compare unit used on every scan step
`timescale 1ns / 1ps

module hnlru_cmp_unit (
    input  logic [hnlru_pkg::STAMP_W-1:0] cur_age,
    input  logic [hnlru_pkg::STAMP_W-1:0] oldest_age,
    input  logic [hnlru_pkg::STAMP_W-1:0] sram_age,
    output hnlru_pkg::cmp_t               cmp
);

    // strict less-than so the lowest position keeps a tie
    assign cmp.lt_oldest = (cur_age < oldest_age);
    assign cmp.lt_sram   = (cur_age < sram_age);

endmodule

>>> hdl/hybrid_sram_nvm_lru_victim_core.sv
// top level: command sequencer, victim scan and label swap for one set
// latency: touch, fill and invalidate complete at the accepting edge, busy stays low
// victim: the scan steps through every way, then the decide step strobes the result, or the swap step after it
// throughput: items are taken only while busy is low, so a new victim item waits until the last one is done;
//   the scan reads one way per cycle through the shared compare unit; other items one per cycle
// reset: asynchronous, clears all stamps, restores flags and labels, counter to one
// results are strobed for one cycle and cannot be stalled
`timescale 1ns / 1ps

module hybrid_sram_nvm_lru_victim_core #(
    parameter int NUM_WAYS  = 16,
    parameter int SRAM_WAYS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  hnlru_pkg::item_t    cmd_item,
    output logic                result_valid,
    output hnlru_pkg::result_t  result
);

    localparam int IDX_W = $clog2(NUM_WAYS);
    localparam int SW    = hnlru_pkg::STAMP_W;
    localparam int LW    = hnlru_pkg::LABEL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SWAP
    } state_t;

    state_t             state_reg, state_next;
    logic [SW-1:0]      counter_reg, counter_next;
    logic [LW-1:0]      last_label_reg, last_label_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]   oldest_idx_reg, oldest_idx_next;
    logic [SW-1:0]      oldest_age_reg, oldest_age_next;
    logic               oldest_nvm_reg, oldest_nvm_next;
    logic [LW-1:0]      oldest_label_reg, oldest_label_next;
    logic [IDX_W-1:0]   sram_idx_reg, sram_idx_next;
    logic [SW-1:0]      sram_age_reg, sram_age_next;
    logic [LW-1:0]      sram_label_reg, sram_label_next;
    logic               have_sram_reg, have_sram_next;
    logic               result_valid_reg, result_valid_next;
    hnlru_pkg::result_t result_reg, result_next;

    logic [SW-1:0]      rd_age;
    logic               rd_nvm;
    logic [LW-1:0]      rd_label;
    logic               age_we;
    logic [SW-1:0]      age_data;
    logic               lbl_we;
    logic [IDX_W-1:0]   lbl_idx;
    logic               lbl_nvm;
    logic [LW-1:0]      lbl_data;
    hnlru_pkg::cmp_t    cmp;
    logic               accept;
    logic               in_range;
    logic               do_swap;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (6'(cmd_item.way_index) < 6'(NUM_WAYS));

    hnlru_way_store #(
        .NUM_WAYS  (NUM_WAYS),
        .SRAM_WAYS (SRAM_WAYS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (scan_reg),
        .rd_age   (rd_age),
        .rd_nvm   (rd_nvm),
        .rd_label (rd_label),
        .age_we   (age_we),
        .age_idx  (IDX_W'(cmd_item.way_index)),
        .age_data (age_data),
        .lbl_we   (lbl_we),
        .lbl_idx  (lbl_idx),
        .lbl_nvm  (lbl_nvm),
        .lbl_data (lbl_data)
    );

    hnlru_cmp_unit u_cmp (
        .cur_age    (rd_age),
        .oldest_age (oldest_age_reg),
        .sram_age   (sram_age_reg),
        .cmp        (cmp)
    );

    assign do_swap = oldest_nvm_reg && have_sram_reg && (oldest_label_reg == last_label_reg);

    always_comb
    begin
        state_next        = state_reg;
        counter_next      = counter_reg;
        last_label_next   = last_label_reg;
        scan_next         = scan_reg;
        oldest_idx_next   = oldest_idx_reg;
        oldest_age_next   = oldest_age_reg;
        oldest_nvm_next   = oldest_nvm_reg;
        oldest_label_next = oldest_label_reg;
        sram_idx_next     = sram_idx_reg;
        sram_age_next     = sram_age_reg;
        sram_label_next   = sram_label_reg;
        have_sram_next    = have_sram_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        age_we            = 1'b0;
        age_data          = counter_reg;
        lbl_we            = 1'b0;
        lbl_idx           = oldest_idx_reg;
        lbl_nvm           = 1'b0;
        lbl_data          = sram_label_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // counter saturates at all ones
                    if (counter_reg != '1)
                        counter_next = counter_reg + SW'(1);
                    unique case (cmd_item.cmd)
                        hnlru_pkg::CMD_TOUCH,
                        hnlru_pkg::CMD_FILL:
                        begin
                            age_we   = in_range;
                            age_data = counter_reg;
                        end
                        hnlru_pkg::CMD_INVAL:
                        begin
                            age_we   = in_range;
                            age_data = '0;
                        end
                        hnlru_pkg::CMD_VICTIM:
                        begin
                            state_next     = ST_SCAN;
                            scan_next      = '0;
                            have_sram_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // position zero seeds the oldest candidate
                if (scan_reg == '0 || cmp.lt_oldest)
                begin
                    oldest_idx_next   = scan_reg;
                    oldest_age_next   = rd_age;
                    oldest_nvm_next   = rd_nvm;
                    oldest_label_next = rd_label;
                end
                if (!rd_nvm && (!have_sram_reg || cmp.lt_sram))
                begin
                    sram_idx_next   = scan_reg;
                    sram_age_next   = rd_age;
                    sram_label_next = rd_label;
                    have_sram_next  = 1'b1;
                end
                if (scan_reg == IDX_W'(NUM_WAYS - 1))
                    state_next = ST_DECIDE;
                else
                    scan_next = scan_reg + IDX_W'(1);
            end
            ST_DECIDE:
            begin
                if (do_swap)
                begin
                    // oldest entry becomes sram and takes the sram label
                    lbl_we     = 1'b1;
                    lbl_idx    = oldest_idx_reg;
                    lbl_nvm    = 1'b0;
                    lbl_data   = sram_label_reg;
                    state_next = ST_SWAP;
                end
                else
                begin
                    last_label_next            = oldest_label_reg;
                    result_valid_next          = 1'b1;
                    result_next.victim_index   = 4'(oldest_idx_reg);
                    result_next.victim_label   = oldest_label_reg;
                    result_next.oldest_was_nvm = oldest_nvm_reg;
                    result_next.swapped        = 1'b0;
                    state_next                 = ST_IDLE;
                end
            end
            ST_SWAP:
            begin
                lbl_we                     = 1'b1;
                lbl_idx                    = sram_idx_reg;
                lbl_nvm                    = 1'b1;
                lbl_data                   = oldest_label_reg;
                last_label_next            = '0;
                result_valid_next          = 1'b1;
                result_next.victim_index   = 4'(sram_idx_reg);
                result_next.victim_label   = oldest_label_reg;
                result_next.oldest_was_nvm = 1'b1;
                result_next.swapped        = 1'b1;
                state_next                 = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            counter_reg      <= SW'(1);
            last_label_reg   <= '0;
            scan_reg         <= '0;
            oldest_idx_reg   <= '0;
            oldest_age_reg   <= '0;
            oldest_nvm_reg   <= 1'b0;
            oldest_label_reg <= '0;
            sram_idx_reg     <= '0;
            sram_age_reg     <= '0;
            sram_label_reg   <= '0;
            have_sram_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            counter_reg      <= counter_next;
            last_label_reg   <= last_label_next;
            scan_reg         <= scan_next;
            oldest_idx_reg   <= oldest_idx_next;
            oldest_age_reg   <= oldest_age_next;
            oldest_nvm_reg   <= oldest_nvm_next;
            oldest_label_reg <= oldest_label_next;
            sram_idx_reg     <= sram_idx_next;
            sram_age_reg     <= sram_age_next;
            sram_label_reg   <= sram_label_next;
            have_sram_reg    <= have_sram_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // results only follow the decide or swap step
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) == ST_DECIDE || $past(state_reg) == ST_SWAP))
        else $error("result strobe outside decide or swap");

    a_swap_clears_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.swapped) |-> (last_label_reg == '0 && result.oldest_was_nvm))
        else $error("swap result without cleared last label");

    a_plain_records_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.swapped) |-> (last_label_reg == result.victim_label))
        else $error("plain result did not record its label");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && counter_reg != '1) |=> (counter_reg == $past(counter_reg) + SW'(1)))
        else $error("access counter did not advance on accept");

endmodule

>>> verif/tb_top.sv
// testbench for the hybrid sram/nvm lru victim block: directed table, then random commands
`timescale 1ns / 1ps

module tb_top;

    localparam int WAYS       = 16;
    localparam int SRAM       = 3;
    localparam int ITEMS      = 950;
    localparam int DRAIN_MAX  = 4000;
    localparam int PLAN_ROWS  = 23;
    localparam int SW         = hnlru_pkg::STAMP_W;
    localparam int LW         = hnlru_pkg::LABEL_W;

    typedef struct {
        hnlru_pkg::item_t   it;
        bit                 typed;
        hnlru_pkg::result_t res;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    hnlru_pkg::item_t   cmd_item;
    logic               result_valid;
    hnlru_pkg::result_t result;

    // lru state of the set as the predictor sees it
    logic [SW-1:0] age [WAYS];
    bit            is_nvm [WAYS];
    logic [LW-1:0] label [WAYS];
    logic [LW-1:0] last_victim_label;
    logic [SW-1:0] access_count;

    hnlru_pkg::result_t victim_q [$];
    int                 errors;
    bit                 quiet;

    // after reset: all stamps zero, so position 0 (sram, label 1) is the oldest;
    // touching the sram ways leaves position 4 oldest, and asking twice swaps it out
    plan_row_t plan [PLAN_ROWS] = '{
        '{'{hnlru_pkg::CMD_VICTIM, 4'd0},  1'b1, '{4'd0, 5'd1, 1'b0, 1'b0}},
        '{'{hnlru_pkg::CMD_TOUCH,  4'd0},  1'b0, '0},
        '{'{hnlru_pkg::CMD_TOUCH,  4'd1},  1'b0, '0},
        '{'{hnlru_pkg::CMD_TOUCH,  4'd2},  1'b0, '0},
        '{'{hnlru_pkg::CMD_TOUCH,  4'd3},  1'b0, '0},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd0},  1'b1, '{4'd4, 5'd5, 1'b1, 1'b0}},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd15}, 1'b1, '{4'd0, 5'd5, 1'b1, 1'b1}},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd0},  1'b0, '0},
        '{'{hnlru_pkg::CMD_FILL,   4'd15}, 1'b0, '0},
        '{'{hnlru_pkg::CMD_INVAL,  4'd15}, 1'b0, '0},
        '{'{hnlru_pkg::CMD_FILL,   4'd8},  1'b0, '0},
        '{'{hnlru_pkg::CMD_TOUCH,  4'd15}, 1'b0, '0},
        '{'{hnlru_pkg::CMD_INVAL,  4'd0},  1'b0, '0},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd10}, 1'b0, '0},
        '{'{hnlru_pkg::CMD_FILL,   4'd5},  1'b0, '0},
        '{'{hnlru_pkg::CMD_INVAL,  4'd10}, 1'b0, '0},
        '{'{hnlru_pkg::CMD_TOUCH,  4'd7},  1'b0, '0},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd5},  1'b0, '0},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd0},  1'b0, '0},
        '{'{hnlru_pkg::CMD_FILL,   4'd0},  1'b0, '0},
        '{'{hnlru_pkg::CMD_INVAL,  4'd4},  1'b0, '0},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd0},  1'b0, '0},
        '{'{hnlru_pkg::CMD_VICTIM, 4'd0},  1'b0, '0}
    };

    hybrid_sram_nvm_lru_victim_core #(
        .NUM_WAYS  (WAYS),
        .SRAM_WAYS (SRAM)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd_item     (cmd_item),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic lru_reset();
        for (int p = 0; p < WAYS; p++)
        begin
            age[p]    = '0;
            is_nvm[p] = (p > SRAM);
            label[p]  = LW'(p + 1);
        end
        last_victim_label = '0;
        access_count      = 32'd1;
    endtask

    task automatic lru_step(input hnlru_pkg::item_t it, output bit has_res,
                            output hnlru_pkg::result_t res);
        logic [SW-1:0] now;
        logic [LW-1:0] lbl;
        int            oldest;
        int            sram_pos;
        int            chosen;
        bit            have_sram;
        bit            was_nvm;
        bit            swap;
        now = access_count;
        if (access_count != '1)
        begin
            access_count = access_count + 1;
        end
        has_res = 1'b0;
        res     = '0;
        case (it.cmd)
            hnlru_pkg::CMD_TOUCH, hnlru_pkg::CMD_FILL:
            begin
                if (int'(it.way_index) < WAYS)
                begin
                    age[it.way_index] = now;
                end
            end
            hnlru_pkg::CMD_INVAL:
            begin
                if (int'(it.way_index) < WAYS)
                begin
                    age[it.way_index] = '0;
                end
            end
            default:
            begin
                oldest    = 0;
                sram_pos  = 0;
                have_sram = 1'b0;
                swap      = 1'b0;
                for (int p = 0; p < WAYS; p++)
                begin
                    if (age[p] < age[oldest])
                    begin
                        oldest = p;
                    end
                    if (!is_nvm[p] && (!have_sram || age[p] < age[sram_pos]))
                    begin
                        sram_pos  = p;
                        have_sram = 1'b1;
                    end
                end
                was_nvm = is_nvm[oldest];
                // nvm picked twice in a row: hand its label to the oldest sram way
                if (was_nvm && have_sram && label[oldest] == last_victim_label)
                begin
                    lbl               = label[oldest];
                    is_nvm[oldest]    = 1'b0;
                    is_nvm[sram_pos]  = 1'b1;
                    label[oldest]     = label[sram_pos];
                    label[sram_pos]   = lbl;
                    last_victim_label = '0;
                    chosen            = sram_pos;
                    swap              = 1'b1;
                end
                else
                begin
                    last_victim_label = label[oldest];
                    chosen            = oldest;
                end
                res.victim_index   = 4'(chosen);
                res.victim_label   = label[chosen];
                res.oldest_was_nvm = was_nvm;
                res.swapped        = swap;
                has_res            = 1'b1;
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input hnlru_pkg::item_t it, input bit typed,
                        input hnlru_pkg::result_t typed_res);
        int                 gap;
        bit                 has_res;
        hnlru_pkg::result_t res;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        cmd_item <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        lru_step(it, has_res, res);
        if (has_res)
        begin
            victim_q.push_back(typed ? typed_res : res);
        end
    endtask

    always @(posedge clk)
    begin
        hnlru_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (victim_q.size() == 0)
            begin
                $error("result with no expectation waiting: index %0d label %0d",
                       result.victim_index, result.victim_label);
                errors++;
            end
            else
            begin
                want = victim_q.pop_front();
                if (result.victim_index !== want.victim_index)
                begin
                    $error("victim_index: expected %0d, actual %0d",
                           want.victim_index, result.victim_index);
                    errors++;
                end
                if (result.victim_label !== want.victim_label)
                begin
                    $error("victim_label: expected %0d, actual %0d",
                           want.victim_label, result.victim_label);
                    errors++;
                end
                if (result.oldest_was_nvm !== want.oldest_was_nvm)
                begin
                    $error("oldest_was_nvm: expected %0b, actual %0b",
                           want.oldest_was_nvm, result.oldest_was_nvm);
                    errors++;
                end
                if (result.swapped !== want.swapped)
                begin
                    $error("swapped: expected %0b, actual %0b",
                           want.swapped, result.swapped);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        hnlru_pkg::item_t it;
        int               sent;
        int               waited;
        start    = 1'b0;
        cmd_item = '0;
        rst_n    = 1'b0;
        errors   = 0;
        quiet    = 1'b0;
        lru_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            send(plan[i].it, plan[i].typed, plan[i].res);
        end

        sent = PLAN_ROWS;
        while (sent < ITEMS)
        begin
            // stretches of back-to-back items now and then
            if (sent % 64 == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 25)
            begin
                // victim pair: the first records the label, the second may swap
                it.cmd       = hnlru_pkg::CMD_VICTIM;
                it.way_index = 4'($urandom_range(0, 15));
                send(it, 1'b0, '0);
                it.way_index = 4'($urandom_range(0, 15));
                send(it, 1'b0, '0);
                sent += 2;
            end
            else
            begin
                it.cmd       = hnlru_pkg::cmd_t'($urandom_range(0, 3));
                it.way_index = 4'($urandom_range(0, 15));
                send(it, 1'b0, '0);
                sent++;
            end
        end
        @(negedge clk);
        start <= 1'b0;

        waited = 0;
        while (victim_q.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (WAYS + 4) @(posedge clk);
        if (victim_q.size() != 0)
        begin
            $error("%0d expected results never arrived", victim_q.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> hybrid_sram_nvm_lru_victim_core.f
hdl/hnlru_pkg.sv
hdl/hnlru_way_store.sv
hdl/hnlru_cmp_unit.sv
hdl/hybrid_sram_nvm_lru_victim_core.sv
verif/tb_top.sv
